>>> hdl/etxpf_pkg.sv
// ============================================================================
// etxpf_pkg: shared types and constants of the Ethernet transmit framer
// Holds the CRC-32 byte update, its constants and the CRC control struct.
// ============================================================================
`default_nettype none

package etxpf_pkg;

  // Width of the saturating frame byte counter.
  localparam int CNT_W = 6;

  // Reflected CRC-32 polynomial and preset value.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Control from the sequencer to the CRC register.
  typedef struct packed {
    logic       upd;
    logic       clr;
    logic [7:0] data;
  } crc_ctl_t;

  // One byte through the reflected CRC-32, least significant bit first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/etxpf_if.sv
// ============================================================================
// etxpf_if: valid/ready channels of the Ethernet transmit framer
// The byte input channel and the byte output channel.
// ============================================================================
`default_nettype none

interface etxpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       no_fcs;

  modport source (output valid, output data_byte, output last_byte, output no_fcs,
                  input ready);
  modport sink (input valid, input data_byte, input last_byte, input no_fcs,
                output ready);
endinterface

interface etxpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

>>> hdl/etxpf_crc.sv
// ============================================================================
// etxpf_crc: running CRC-32 register
// Folds one byte per cycle into the CRC while update is requested and returns to the preset on clear.
// ============================================================================
`default_nettype none

module etxpf_crc (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire etxpf_pkg::crc_ctl_t ctl,
  output logic [31:0]              crc
);
  import etxpf_pkg::*;

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;

  // Clear wins over update: a frame sent without FCS still ends in the preset.
  always_comb begin
    crc_nxt = crc_r;
    if (ctl.clr) begin
      crc_nxt = CRC_INIT;
    end else if (ctl.upd) begin
      crc_nxt = crc_byte(crc_r, ctl.data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

`default_nettype wire

>>> hdl/etxpf_seq.sv
// ============================================================================
// etxpf_seq: frame sequencer with output register
// Passes data bytes, then, unless the last byte has no_fcs set, generates any pad bytes and the four FCS bytes.
// ============================================================================
`default_nettype none

module etxpf_seq #(
  parameter int MIN_FRAME = 60
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  etxpf_in_if.sink                  in_ch,
  etxpf_out_if.source               out_ch,
  input  wire logic [31:0]          crc,
  output etxpf_pkg::crc_ctl_t       crc_ctl
);
  import etxpf_pkg::*;

  localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_FRAME);

  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD,
    PH_FCS
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic             advance;
  logic             in_acc;
  logic [CNT_W-1:0] cnt_sat;
  logic [31:0]      fcs;

  // The output register may load whenever it is empty or being drained.
  assign advance = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (phase_r == PH_DATA) && advance;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cnt_sat = (cnt_r < MIN_CNT) ? cnt_r + CNT_W'(1) : cnt_r;
  assign fcs = ~crc;

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    crc_ctl       = '0;

    case (phase_r)
      PH_DATA: begin
        if (in_acc) begin
          crc_ctl.upd   = 1'b1;
          crc_ctl.data  = in_ch.data_byte;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = in_ch.data_byte;
          out_last_nxt  = in_ch.last_byte && in_ch.no_fcs;
          cnt_nxt       = cnt_sat;
          if (in_ch.last_byte) begin
            if (in_ch.no_fcs) begin
              crc_ctl.clr = 1'b1;
              cnt_nxt     = '0;
            end else begin
              idx_nxt   = '0;
              phase_nxt = (cnt_sat < MIN_CNT) ? PH_PAD : PH_FCS;
            end
          end
        end
      end
      PH_PAD: begin
        if (advance) begin
          crc_ctl.upd   = 1'b1;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'd0;
          out_last_nxt  = 1'b0;
          cnt_nxt       = cnt_sat;
          if (!(cnt_sat < MIN_CNT)) begin
            phase_nxt = PH_FCS;
          end
        end
      end
      PH_FCS: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = fcs[8*idx_r +: 8];
          out_last_nxt  = (idx_r == 2'd3);
          idx_nxt       = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            crc_ctl.clr = 1'b1;
            cnt_nxt     = '0;
            phase_nxt   = PH_DATA;
          end
        end
      end
      default: begin
        phase_nxt = PH_DATA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_DATA;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

endmodule

`default_nettype wire

>>> hdl/ethernet_tx_pad_and_fcs.sv
// A byte accepted at a clock edge is held in the output register and shown after that edge.
// Throughput: one data byte per cycle outside the tail, while the output is not stalled;
// the output register takes a new byte while draining. After a last byte with FCS, the
// input is held off for the pad bytes and four FCS bytes, one per cycle while output drains.
// Reset (synchronous, rst_n low): CRC preset to all ones, byte count zero, output empty.
// ============================================================================
// ethernet_tx_pad_and_fcs: Ethernet transmit framer with padding and FCS
// Passes frame bytes; unless no_fcs is set, pads short frames with zeros and appends the CRC-32.
// ============================================================================
`default_nettype none

module ethernet_tx_pad_and_fcs #(
  parameter int MIN_FRAME = 60
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  etxpf_in_if.sink    in_ch,
  etxpf_out_if.source out_ch
);
  import etxpf_pkg::*;

  // Control from the sequencer to the CRC register, and the running CRC back.
  crc_ctl_t    crc_ctl;
  logic [31:0] crc_val;

  // The CRC register folds in the data and pad bytes of a frame with FCS. It is
  // preset again once a frame's final byte has been taken or generated.
  etxpf_crc u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (crc_ctl),
    .crc   (crc_val)
  );

  // The sequencer owns the handshakes, the byte counter and the output
  // register. While it sends the pad and FCS tail, it keeps the input stalled;
  // otherwise it accepts one byte per cycle as long as the output drains.
  etxpf_seq #(
    .MIN_FRAME (MIN_FRAME)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .crc     (crc_val),
    .crc_ctl (crc_ctl)
  );

`ifndef SYNTHESIS
  // A frame sent without FCS leaves the CRC at its preset for the next frame.
  a_crc_preset_after_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_byte && in_ch.no_fcs)
      |=> (crc_val == CRC_INIT))
    else $error("CRC not preset after a frame without FCS");

  // Once a last byte with FCS is taken, the tail holds the input off.
  a_tail_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.last_byte && !in_ch.no_fcs)
      |=> !in_ch.ready)
    else $error("Input accepted while the pad and FCS tail is pending");

  // The CRC never moves while the sequencer asks for no update and no clear.
  a_crc_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!crc_ctl.upd && !crc_ctl.clr) |=> $stable(crc_val))
    else $error("CRC changed without a request");
`endif

endmodule

`default_nettype wire
